[src/stiu_pkg.sv]
// ----------------------------------------------------------------------------
// Segment/triangle intersection package
// Shared constants for the intersection unit and its channel interfaces.
// ----------------------------------------------------------------------------
package stiu_pkg;

	localparam int NUM_LANES = 3;
	localparam int LANE_X    = 0;
	localparam int LANE_Y    = 1;
	localparam int LANE_Z    = 2;

endpackage

[src/stiu_in_if.sv]
// ----------------------------------------------------------------------------
// Intersection request channel
// Valid/ready channel that carries one segment and one triangle per transaction.
// ----------------------------------------------------------------------------
interface stiu_in_if
	import stiu_pkg::*;
#(
	parameter int COORD_BITS = 16
);
	logic                              valid;
	logic                              ready;
	logic [NUM_LANES*COORD_BITS-1:0]   seg_start;
	logic [NUM_LANES*COORD_BITS-1:0]   seg_end;
	logic [NUM_LANES*COORD_BITS-1:0]   vert_a;
	logic [NUM_LANES*COORD_BITS-1:0]   vert_b;
	logic [NUM_LANES*COORD_BITS-1:0]   vert_c;

	modport source (output valid, seg_start, seg_end, vert_a, vert_b, vert_c, input ready);
	modport sink (input valid, seg_start, seg_end, vert_a, vert_b, vert_c, output ready);
endinterface

[src/stiu_out_if.sv]
// ----------------------------------------------------------------------------
// Intersection result channel
// Valid/ready channel that carries one hit flag, point and normal per transaction.
// ----------------------------------------------------------------------------
interface stiu_out_if
	import stiu_pkg::*;
#(
	parameter int COORD_BITS = 16
);
	logic                               valid;
	logic                               ready;
	logic                               hit;
	logic signed [COORD_BITS-1:0]       point_x;
	logic signed [COORD_BITS-1:0]       point_y;
	logic signed [COORD_BITS-1:0]       point_z;
	logic signed [2*COORD_BITS+1:0]     normal_x;
	logic signed [2*COORD_BITS+1:0]     normal_y;
	logic signed [2*COORD_BITS+1:0]     normal_z;

	modport source (output valid, hit, point_x, point_y, point_z, normal_x, normal_y,
		normal_z, input ready);
	modport sink (input valid, hit, point_x, point_y, point_z, normal_x, normal_y,
		normal_z, output ready);
endinterface

[src/stiu_floor_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module stiu_floor_div
	import stiu_pkg::*;
#(
	parameter int NUMW = 71,
	parameter int DENW = 53,
	parameter int QB   = 18
) (
	input  logic            clk,
	input  logic            en,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic [QB-1:0]   quo
);
	localparam int SW = NUMW + QB;

	logic [NUMW-1:0] rem_s [QB];
	logic [DENW-1:0] den_s [QB];
	logic [QB-1:0]   quo_s [QB];

	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int K = QB - 1 - j;
		logic [NUMW-1:0] rem_in;
		logic [DENW-1:0] den_in;
		logic [QB-1:0]   quo_in;
		logic [SW-1:0]   rem_ext;
		logic [SW-1:0]   den_sh;
		logic [SW-1:0]   diff;
		logic            ge;

		if (j == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign den_in = den_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		always_comb begin
			rem_ext = SW'(rem_in);
			den_sh  = SW'(den_in) << K;
			ge      = rem_ext >= den_sh;
			diff    = rem_ext - den_sh;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? diff[NUMW-1:0] : rem_in;
				den_s[j] <= den_in;
				quo_s[j] <= quo_in | (QB'(ge) << K);
			end
		end
	end

	assign quo = quo_s[QB-1];
endmodule

[src/segment_triangle_intersection_unit.sv]
// ----------------------------------------------------------------------------
// Segment/triangle intersection unit
// Exact integer barycentric test of a segment against the front side of a
// triangle, giving the floor-rounded crossing point and the raw normal.
// ----------------------------------------------------------------------------
// The unit accepts one transaction per clock unless the output stalls, and returns
// results in order. It has six arithmetic stages, a divider that retires one
// quotient bit per stage for COORD_BITS + 2 stages, and the output register.
// The whole pipeline holds while a finished result is not taken; a miss returns
// all fields as zero.
module segment_triangle_intersection_unit
	import stiu_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	stiu_in_if.sink     item,
	stiu_out_if.source  result
);
	localparam int C    = COORD_BITS;
	localparam int D    = C + 1;
	localparam int NW   = 2 * C + 2;
	localparam int PW   = D + NW;
	localparam int DW   = PW + 2;
	localparam int H    = (DW - 1) / 2;
	localparam int HH   = DW - 1 - H;
	localparam int PPW  = D + HH + 1;
	localparam int NUMW = D + DW + 1;
	localparam int QB   = D + 1;

	logic en;
	logic out_valid_q;

	assign en         = !out_valid_q || result.ready;
	assign item.ready = en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic v_dly [QB];

	logic signed [C-1:0]  a_s1 [NUM_LANES], a_s2 [NUM_LANES], a_s3 [NUM_LANES];
	logic signed [C-1:0]  a_s4 [NUM_LANES], a_s5 [NUM_LANES], a_s6 [NUM_LANES];
	logic signed [D-1:0]  ab_s1 [NUM_LANES], ac_s1 [NUM_LANES];
	logic signed [D-1:0]  qp_s1 [NUM_LANES], ap_s1 [NUM_LANES];
	logic signed [D-1:0]  ab_s2 [NUM_LANES], ac_s2 [NUM_LANES];
	logic signed [D-1:0]  qp_s2 [NUM_LANES], ap_s2 [NUM_LANES];
	logic signed [D-1:0]  ab_s3 [NUM_LANES], ac_s3 [NUM_LANES];
	logic signed [D-1:0]  ab_s4 [NUM_LANES], ac_s4 [NUM_LANES];
	logic signed [NW-1:0] n_s2 [NUM_LANES], e_s2 [NUM_LANES];
	logic signed [NW-1:0] n_s3 [NUM_LANES], n_s4 [NUM_LANES], n_s5 [NUM_LANES];
	logic signed [NW-1:0] n_s6 [NUM_LANES];
	logic signed [PW-1:0] pd_s3 [NUM_LANES], pt_s3 [NUM_LANES];
	logic signed [PW-1:0] pv_s3 [NUM_LANES], pw_s3 [NUM_LANES];
	logic signed [DW-1:0] d_s4, t_s4, v_s4_val, w_s4;
	logic signed [DW-1:0] d_s5, d_s6;
	logic                 hit_s5, hit_s6;
	logic signed [PPW-1:0] pvl_s5 [NUM_LANES], pvh_s5 [NUM_LANES];
	logic signed [PPW-1:0] pwl_s5 [NUM_LANES], pwh_s5 [NUM_LANES];
	logic [NUMW-1:0]      xnum_s6 [NUM_LANES];

	logic                 hit_dly [QB];
	logic signed [C-1:0]  a_dly [QB][NUM_LANES];
	logic signed [NW-1:0] n_dly [QB][NUM_LANES];
	logic [QB-1:0]        quo [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		localparam int J = (i + 1) % NUM_LANES;
		localparam int K = (i + 2) % NUM_LANES;
		logic signed [C-1:0] p, q, a, b, c;

		assign p = item.seg_start[C*i +: C];
		assign q = item.seg_end[C*i +: C];
		assign a = item.vert_a[C*i +: C];
		assign b = item.vert_b[C*i +: C];
		assign c = item.vert_c[C*i +: C];

		always_ff @(posedge clk) begin
			if (en) begin
				a_s1[i]  <= a;
				ab_s1[i] <= D'(b) - D'(a);
				ac_s1[i] <= D'(c) - D'(a);
				qp_s1[i] <= D'(p) - D'(q);
				ap_s1[i] <= D'(p) - D'(a);

				a_s2[i]  <= a_s1[i];
				ab_s2[i] <= ab_s1[i];
				ac_s2[i] <= ac_s1[i];
				qp_s2[i] <= qp_s1[i];
				ap_s2[i] <= ap_s1[i];
				n_s2[i]  <= NW'(ab_s1[J] * ac_s1[K]) - NW'(ab_s1[K] * ac_s1[J]);
				e_s2[i]  <= NW'(qp_s1[J] * ap_s1[K]) - NW'(qp_s1[K] * ap_s1[J]);

				a_s3[i]  <= a_s2[i];
				ab_s3[i] <= ab_s2[i];
				ac_s3[i] <= ac_s2[i];
				n_s3[i]  <= n_s2[i];
				pd_s3[i] <= PW'(qp_s2[i] * n_s2[i]);
				pt_s3[i] <= PW'(ap_s2[i] * n_s2[i]);
				pv_s3[i] <= PW'(ac_s2[i] * e_s2[i]);
				pw_s3[i] <= PW'(ab_s2[i] * e_s2[i]);

				a_s4[i]  <= a_s3[i];
				ab_s4[i] <= ab_s3[i];
				ac_s4[i] <= ac_s3[i];
				n_s4[i]  <= n_s3[i];

				a_s5[i]   <= a_s4[i];
				n_s5[i]   <= n_s4[i];
				pvl_s5[i] <= PPW'(ab_s4[i] * $signed({1'b0, v_s4_val[H-1:0]}));
				pvh_s5[i] <= PPW'(ab_s4[i] * $signed({1'b0, v_s4_val[DW-2:H]}));
				pwl_s5[i] <= PPW'(ac_s4[i] * $signed({1'b0, w_s4[H-1:0]}));
				pwh_s5[i] <= PPW'(ac_s4[i] * $signed({1'b0, w_s4[DW-2:H]}));

				a_s6[i]    <= a_s5[i];
				n_s6[i]    <= n_s5[i];
				xnum_s6[i] <= NUMW'(NUMW'(pvl_s5[i]) + (NUMW'(pvh_s5[i]) <<< H)
					+ NUMW'(pwl_s5[i]) + (NUMW'(pwh_s5[i]) <<< H) + (NUMW'(d_s5) <<< D));
			end
		end

		stiu_floor_div #(
			.NUMW (NUMW),
			.DENW (DW),
			.QB   (QB)
		) u_div (
			.clk (clk),
			.en  (en),
			.num (xnum_s6[i]),
			.den (d_s6),
			.quo (quo[i])
		);
	end

	logic signed [DW:0] vw_sum;
	logic               hit_chk;

	always_comb begin
		vw_sum  = (DW+1)'(v_s4_val) + (DW+1)'(w_s4);
		hit_chk = (d_s4 > 0) && (t_s4 > 0) && (t_s4 <= d_s4) && !v_s4_val[DW-1]
			&& (v_s4_val <= d_s4) && !w_s4[DW-1] && (vw_sum <= (DW+1)'(d_s4));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4     <= DW'(pd_s3[LANE_X]) + DW'(pd_s3[LANE_Y]) + DW'(pd_s3[LANE_Z]);
			t_s4     <= DW'(pt_s3[LANE_X]) + DW'(pt_s3[LANE_Y]) + DW'(pt_s3[LANE_Z]);
			v_s4_val <= DW'(pv_s3[LANE_X]) + DW'(pv_s3[LANE_Y]) + DW'(pv_s3[LANE_Z]);
			w_s4     <= -(DW'(pw_s3[LANE_X]) + DW'(pw_s3[LANE_Y]) + DW'(pw_s3[LANE_Z]));
			d_s5     <= d_s4;
			hit_s5   <= hit_chk;
			d_s6     <= d_s5;
			hit_s6   <= hit_s5;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dly[k] <= 1'b0;
			end else if (en) begin
				v_dly[k] <= (k == 0) ? v_s6 : v_dly[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (k == 0) begin
					hit_dly[k] <= hit_s6;
					a_dly[k]   <= a_s6;
					n_dly[k]   <= n_s6;
				end else begin
					hit_dly[k] <= hit_dly[(k == 0) ? 0 : k-1];
					a_dly[k]   <= a_dly[(k == 0) ? 0 : k-1];
					n_dly[k]   <= n_dly[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	logic                 hit_q;
	logic signed [C-1:0]  point_q [NUM_LANES];
	logic signed [NW-1:0] normal_q [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_dly[QB-1];
		end
	end

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_out
		always_ff @(posedge clk) begin
			if (en) begin
				point_q[i]  <= hit_dly[QB-1] ? C'(a_dly[QB-1][i] + $signed(quo[i][C-1:0]))
					: '0;
				normal_q[i] <= hit_dly[QB-1] ? n_dly[QB-1][i] : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_q <= hit_dly[QB-1];
		end
	end

	assign result.valid    = out_valid_q;
	assign result.hit      = hit_q;
	assign result.point_x  = point_q[LANE_X];
	assign result.point_y  = point_q[LANE_Y];
	assign result.point_z  = point_q[LANE_Z];
	assign result.normal_x = normal_q[LANE_X];
	assign result.normal_y = normal_q[LANE_Y];
	assign result.normal_z = normal_q[LANE_Z];
endmodule

[test/segment_triangle_intersection_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment/triangle intersection unit testbench
// Drives segment and triangle transactions with random gaps and result stalls,
// predicts hit, crossing point and normal with exact integer arithmetic, and
// compares each result transaction in order against the prediction.
// ----------------------------------------------------------------------------
module segment_triangle_intersection_unit_tb;
	import stiu_pkg::*;

	localparam int CB = 16;
	localparam int W = NUM_LANES * CB;
	localparam int NB = 2 * CB + 2;
	localparam int LATENCY = CB + 9;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic            hit;
		logic [CB-1:0]   px, py, pz;
		logic [NB-1:0]   nx, ny, nz;
	} crossing_t;

	typedef logic signed [127:0] wide_t;

	int errors = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic wide_t coord(input logic [W-1:0] word, input int i);
		logic signed [CB-1:0] c;
		c = word[i*CB +: CB];
		return wide_t'(c);
	endfunction

	function automatic wide_t floor_div(input wide_t num, input wide_t den);
		wide_t q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic crossing_t predict_crossing(input logic [W-1:0] p_w, q_w, a_w, b_w,
			c_w);
		wide_t a[3], ab[3], ac[3], qp[3], ap[3], n[3], e[3];
		wide_t d, t, v, w, f;
		crossing_t r;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			a[i] = coord(a_w, i);
			ab[i] = coord(b_w, i) - a[i];
			ac[i] = coord(c_w, i) - a[i];
			qp[i] = coord(p_w, i) - coord(q_w, i);
			ap[i] = coord(p_w, i) - a[i];
		end
		n[0] = ab[1]*ac[2] - ab[2]*ac[1];
		n[1] = ab[2]*ac[0] - ab[0]*ac[2];
		n[2] = ab[0]*ac[1] - ab[1]*ac[0];
		d = qp[0]*n[0] + qp[1]*n[1] + qp[2]*n[2];
		if (d <= 0) return r;
		t = ap[0]*n[0] + ap[1]*n[1] + ap[2]*n[2];
		if (t <= 0 || t > d) return r;
		e[0] = qp[1]*ap[2] - qp[2]*ap[1];
		e[1] = qp[2]*ap[0] - qp[0]*ap[2];
		e[2] = qp[0]*ap[1] - qp[1]*ap[0];
		v = ac[0]*e[0] + ac[1]*e[1] + ac[2]*e[2];
		if (v < 0 || v > d) return r;
		w = -(ab[0]*e[0] + ab[1]*e[1] + ab[2]*e[2]);
		if (w < 0 || v + w > d) return r;
		r.hit = 1'b1;
		f = floor_div(ab[0]*v + ac[0]*w, d); r.px = CB'(a[0] + f);
		f = floor_div(ab[1]*v + ac[1]*w, d); r.py = CB'(a[1] + f);
		f = floor_div(ab[2]*v + ac[2]*w, d); r.pz = CB'(a[2] + f);
		r.nx = NB'(n[0]); r.ny = NB'(n[1]); r.nz = NB'(n[2]);
		return r;
	endfunction

	class crossing_scoreboard;
		crossing_t pending[$];
		int hits = 0;

		function void note_request(input logic [W-1:0] p, q, a, b, c);
			pending.push_back(predict_crossing(p, q, a, b, c));
		endfunction

		task check_result(input crossing_t got);
			crossing_t exp;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			exp = pending.pop_front();
			if (got.hit) hits++;
			if (got.hit !== exp.hit) report($sformatf("hit %b exp %b", got.hit, exp.hit));
			if (got.px !== exp.px) report($sformatf("point_x %h exp %h", got.px, exp.px));
			if (got.py !== exp.py) report($sformatf("point_y %h exp %h", got.py, exp.py));
			if (got.pz !== exp.pz) report($sformatf("point_z %h exp %h", got.pz, exp.pz));
			if (got.nx !== exp.nx) report($sformatf("normal_x %h exp %h", got.nx, exp.nx));
			if (got.ny !== exp.ny) report($sformatf("normal_y %h exp %h", got.ny, exp.ny));
			if (got.nz !== exp.nz) report($sformatf("normal_z %h exp %h", got.nz, exp.nz));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint cycles = 0;
	bit stim_done = 1'b0;
	crossing_scoreboard board = new();

	stiu_in_if #(.COORD_BITS(CB)) item_ch ();
	stiu_out_if #(.COORD_BITS(CB)) result_ch ();

	segment_triangle_intersection_unit #(.COORD_BITS(CB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch.sink),
		.result(result_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		item_ch.valid = 1'b0;
		item_ch.seg_start = '0;
		item_ch.seg_end = '0;
		item_ch.vert_a = '0;
		item_ch.vert_b = '0;
		item_ch.vert_c = '0;
		result_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [CB-1:0] rand_coord(input int mode);
		case (mode)
			0: return CB'($urandom);
			1: return CB'($urandom_range(0, 4095)) - CB'(2048);
			default: return CB'($urandom_range(0, 63)) - CB'(32);
		endcase
	endfunction

	function automatic logic [W-1:0] rand_point(input int mode);
		return {rand_coord(mode), rand_coord(mode), rand_coord(mode)};
	endfunction

	function automatic logic [W-1:0] pack3(input int x, y, z);
		return {CB'(z), CB'(y), CB'(x)};
	endfunction

	task automatic send_request(input logic [W-1:0] p, q, a, b, c);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.seg_start <= p;
		item_ch.seg_end <= q;
		item_ch.vert_a <= a;
		item_ch.vert_b <= b;
		item_ch.vert_c <= c;
		do @(posedge clk); while (!item_ch.ready);
		board.note_request(p, q, a, b, c);
	endtask

	// Half the time, aim the segment through the triangle's centroid, from either side at random.
	task automatic send_hit_shaped(input int mode);
		logic [W-1:0] a, b, c, p, q;
		int s;
		a = rand_point(mode);
		b = rand_point(mode);
		c = rand_point(mode);
		p = rand_point(mode);
		q = rand_point(mode);
		if ($urandom_range(0, 1)) begin
			for (int i = 0; i < 3; i++) begin
				s = ($signed(a[i*CB +: CB]) + $signed(b[i*CB +: CB])
					+ $signed(c[i*CB +: CB])) / 3;
				p[i*CB +: CB] = CB'(s + $signed(p[i*CB +: CB]));
				q[i*CB +: CB] = CB'(2 * s - $signed(p[i*CB +: CB]));
			end
		end
		if ($urandom_range(0, 1)) send_request(p, q, a, b, c);
		else send_request(q, p, a, b, c);
	endtask

	initial begin
		logic [W-1:0] a, b, c;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		a = pack3(0, 0, 0); b = pack3(256, 0, 0); c = pack3(0, 256, 0);
		send_request(pack3(64, 64, 256), pack3(64, 64, -256), a, b, c);
		send_request(pack3(64, 64, -256), pack3(64, 64, 256), a, b, c);
		send_request(pack3(64, 64, 256), pack3(64, 64, 256), a, b, c);
		send_request(pack3(64, 64, 256), pack3(64, 64, 0), a, b, c);
		send_request(pack3(64, 64, 0), pack3(64, 64, -256), a, b, c);
		send_request(pack3(64, 64, 256), pack3(64, 64, 10), a, b, c);
		send_request(pack3(0, 0, 256), pack3(0, 0, -256), a, b, c);
		send_request(pack3(128, 128, 256), pack3(128, 128, -256), a, b, c);
		send_request(pack3(200, 200, 256), pack3(200, 200, -256), a, b, c);
		send_request(pack3(-1, 64, 256), pack3(-1, 64, -256), a, b, c);
		send_request(pack3(64, -1, 256), pack3(64, -1, -256), a, b, c);
		send_request(pack3(1, 1, 3), pack3(2, 1, -4), a, b, c);
		send_request(pack3(64, 64, 256), pack3(64, 64, -256), a, a, c);
		send_request(pack3(10, 10, 256), pack3(70, 20, -256), a, b, c);
		send_request({W{1'b1}}, {W{1'b0}}, a, b, c);
		send_request(pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767),
			pack3(32767, -32768, 0), pack3(-32768, 32767, 0), pack3(-32768, -32768, 32767));
		send_request(pack3(0, 0, 32767), pack3(0, 0, -32768),
			pack3(-32768, -32768, 0), pack3(32767, -32768, 0), pack3(-32768, 32767, 0));
		send_request(pack3(0, 0, 32767), pack3(0, 0, -32768),
			pack3(32767, 32767, 0), pack3(-32768, 32767, 0), pack3(32767, -32768, 0));
		send_request(pack3(5, 7, 300), pack3(9, -3, -300), pack3(-300, -300, 1),
			pack3(300, -300, -2), pack3(0, 300, 3));
		for (int k = 0; k < 650; k++) begin
			if ($urandom_range(0, 4) == 0)
				send_request(rand_point(0), rand_point(0), rand_point(0), rand_point(0),
					rand_point(0));
			else
				send_hit_shaped($urandom_range(0, 2));
		end
		item_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready)
			board.check_result({result_ch.hit, result_ch.point_x, result_ch.point_y,
				result_ch.point_z, result_ch.normal_x, result_ch.normal_y,
				result_ch.normal_z});
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	initial begin
		wait (stim_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (errors == 0 && board.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
